[rtl/core/bbes_pkg.sv]
// ----------------------------------------------------------------------------
// bbes_pkg
// shared constants and helpers for the bouncing body euler step block
// ----------------------------------------------------------------------------
package bbes_pkg;

  localparam int FracBitsDefault = 24;
  localparam int DtFrac          = 20;
  localparam logic [25:0] DtUsMax = 26'h3FFFFFF;
  localparam int UsPerS          = 1000000;
  // floor(2^50 / 10^6): us * DtRecip >> 30 is dt in Q.20, at most one low
  localparam logic signed [31:0] DtRecip = 32'sd1125899906;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GRAV_X   = 3'd0,
    REG_GRAV_Y   = 3'd1,
    REG_GRAV_Z   = 3'd2,
    REG_DAMPING  = 3'd3,
    REG_HALF_H   = 3'd4,
    REG_STOP_SQ  = 3'd5,
    REG_REST_LIM = 3'd6
  } reg_idx_t;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // saturate a 34 bit signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

[rtl/core/bbes_if.sv]
// ----------------------------------------------------------------------------
// bbes_if
// valid/ready channel interfaces for items, results and configuration
// ----------------------------------------------------------------------------
interface bbes_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] time_us;
  logic signed [31:0] load_pos_x;
  logic signed [31:0] load_pos_y;
  logic signed [31:0] load_pos_z;
  logic signed [31:0] load_vel_x;
  logic signed [31:0] load_vel_y;
  logic signed [31:0] load_vel_z;
  modport source (output valid, cmd, time_us, load_pos_x, load_pos_y, load_pos_z,
                  load_vel_x, load_vel_y, load_vel_z, input ready);
  modport sink (input valid, cmd, time_us, load_pos_x, load_pos_y, load_pos_z,
                load_vel_x, load_vel_y, load_vel_z, output ready);
endinterface

interface bbes_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface bbes_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/bbes_mul.sv]
// ----------------------------------------------------------------------------
// bbes_mul
// shared rounding multiplier: round(a*b / 2^sh), ties away from zero
// ----------------------------------------------------------------------------
module bbes_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic               sh16,
  output logic signed [33:0] res,
  output logic signed [63:0] raw
);
  logic signed [63:0] prod;
  logic               sh16_q;
  logic               neg;
  logic [63:0]        mag;
  logic [63:0]        rnd;

  // product register
  always_ff @(posedge clk) begin
    prod   <= a * b;
    sh16_q <= sh16;
  end

  // round magnitude then restore sign
  always_comb begin
    neg = prod[63];
    mag = neg ? 64'(-prod) : 64'(prod);
    if (sh16_q) rnd = (mag + 64'd32768) >> 16;
    else        rnd = (mag + 64'd524288) >> 20;
    // past 2^32 any later 32 bit saturating sum ends at the same rail
    if (rnd > 64'h1_0000_0000) rnd = 64'h1_0000_0000;
    res = neg ? -$signed(rnd[33:0]) : $signed(rnd[33:0]);
  end

  assign raw = prod;
endmodule

[rtl/core/bouncing_body_euler_step_top.sv]
// ----------------------------------------------------------------------------
// bouncing_body_euler_step_top
// one body, explicit euler step with floor bounce, damping and speed snap
// ----------------------------------------------------------------------------
// a load and an advance with no velocity and no gravity skip the multiplier;
//   a moving advance takes 14 to 20 products from it
// throughput: one item at a time; the next input beat is taken only after the
//   result beat has left; the shared multiplier sets the step
// reset: state and time clear to zero, registers take their defaults
module bouncing_body_euler_step_top #(
  parameter int FRAC_BITS = bbes_pkg::FracBitsDefault
) (
  input logic       clk,
  input logic       rst,
  bbes_in_if.sink   in_ch,
  bbes_out_if.source out_ch,
  bbes_cfg_if.sink  cfg
);
  typedef enum logic [3:0] {
    S_IDLE, S_RECIP, S_CHECK, S_POS, S_BOUNCE, S_SNAP1, S_GRAV, S_DAMP1, S_DAMP2,
    S_SNAP2, S_OUT
  } state_t;

  state_t state;
  logic signed [31:0] gx, gy, gz;
  logic [15:0] damping;
  logic [30:0] half_h;
  logic [62:0] stop_sq;
  logic [30:0] rest_lim;

  logic signed [31:0] p [3];
  logic signed [31:0] v [3];
  logic [63:0] last_t;
  logic [63:0] sq_acc;
  logic signed [33:0] d_tmp;
  logic [1:0]  lane;
  logic        phase;
  logic [25:0] us_q;
  logic [26:0] dt;
  logic        resting, has_g;

  logic signed [31:0] ma, mb;
  logic               msh16;
  logic signed [33:0] mres;
  logic signed [63:0] mraw;
  logic [63:0] us_diff;
  logic [25:0] us_sat;
  logic [63:0] q_est;
  logic [45:0] dt_rem;
  logic [63:0] sq_sum;
  logic signed [31:0] half_s;
  logic signed [31:0] p_sum;

  // frac bits shape the default floor level
  localparam logic [30:0] HalfHReset = 31'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);

  bbes_mul u_mul (.clk(clk), .a(ma), .b(mb), .sh16(msh16), .res(mres), .raw(mraw));

  function automatic logic signed [31:0] p_sum_v(input logic signed [31:0] a,
                                                 input logic signed [33:0] b);
    return bbes_pkg::sat32(34'(a) + b);
  endfunction

  assign us_diff = in_ch.time_us - last_t;
  assign us_sat  = (us_diff > 64'(bbes_pkg::DtUsMax)) ? bbes_pkg::DtUsMax : us_diff[25:0];
  // dt estimate from the reciprocal product, rounded, then the exact remainder
  assign q_est   = 64'(mraw) + (64'd1 << 29);
  assign dt_rem  = {us_q, 20'd0} + 46'(bbes_pkg::UsPerS / 2) - mraw[45:0];
  assign sq_sum  = sq_acc + 64'(mraw);
  assign half_s  = $signed({1'b0, half_h});
  assign p_sum   = bbes_pkg::sat32(34'(p[lane]) + mres);
  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  // multiplier operand select
  always_comb begin
    ma = v[lane];
    mb = 32'(dt);
    msh16 = 1'b0;
    case (state)
      S_RECIP: begin
        ma = $signed({6'd0, us_q});
        mb = bbes_pkg::DtRecip;
      end
      S_CHECK: begin
        ma = $signed({5'd0, dt});
        mb = 32'(bbes_pkg::UsPerS);
      end
      S_SNAP1, S_SNAP2: mb = v[lane];
      S_GRAV:  ma = (lane == 2'd0) ? gx : (lane == 2'd1) ? gy : gz;
      S_DAMP1: begin
        mb = $signed({16'd0, damping});
        msh16 = 1'b1;
      end
      S_DAMP2: ma = d_tmp[31:0];
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gx <= '0; gy <= '0; gz <= '0;
      damping  <= 16'd64881;
      half_h   <= HalfHReset;
      stop_sq  <= 63'd1;
      rest_lim <= 31'd16;
    end else if (cfg.valid) begin
      case (cfg.index)
        bbes_pkg::REG_GRAV_X:   gx <= cfg.data[31:0];
        bbes_pkg::REG_GRAV_Y:   gy <= cfg.data[31:0];
        bbes_pkg::REG_GRAV_Z:   gz <= cfg.data[31:0];
        bbes_pkg::REG_DAMPING:  damping <= cfg.data[15:0];
        bbes_pkg::REG_HALF_H:   half_h <= cfg.data[30:0];
        bbes_pkg::REG_STOP_SQ:  stop_sq <= cfg.data[62:0];
        bbes_pkg::REG_REST_LIM: rest_lim <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // sequencer: state, body registers and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      last_t <= '0;
      for (int i = 0; i < 3; i++) begin
        p[i] <= '0;
        v[i] <= '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          last_t <= in_ch.time_us;
          if (in_ch.cmd == bbes_pkg::CMD_LOAD) begin
            p[0] <= in_ch.load_pos_x; p[1] <= in_ch.load_pos_y; p[2] <= in_ch.load_pos_z;
            v[0] <= in_ch.load_vel_x; v[1] <= in_ch.load_vel_y; v[2] <= in_ch.load_vel_z;
            state <= S_OUT;
          end else begin
            has_g <= (gx != 0) || (gy != 0) || (gz != 0);
            resting <= (p[1] <= half_s) && (34'(v[1]) >= -34'($signed({1'b0, rest_lim})))
                       && (34'(v[1]) <= 34'($signed({1'b0, rest_lim}))) && gy[31];
            us_q  <= us_sat;
            phase <= 1'b0;
            state <= ((v[0] != 0) || (v[1] != 0) || (v[2] != 0) ||
                      (gx != 0) || (gy != 0) || (gz != 0)) ? S_RECIP : S_OUT;
          end
        end
        // dt estimate by reciprocal multiply
        S_RECIP: begin
          phase <= !phase;
          if (phase) begin
            dt <= q_est[56:30];
            state <= S_CHECK;
          end
        end
        // remainder check lifts a low estimate by one
        S_CHECK: begin
          phase <= !phase;
          if (phase) begin
            if (dt_rem >= 46'(bbes_pkg::UsPerS)) dt <= dt + 27'd1;
            lane <= '0;
            state <= S_POS;
          end
        end
        S_POS: begin
          phase <= !phase;
          if (phase) begin
            p[lane] <= p_sum;
            if (lane == 2'd2) state <= S_BOUNCE;
            lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
          end
        end
        S_BOUNCE: begin
          sq_acc <= '0;
          if (p[1] <= half_s) begin
            v[1] <= bbes_pkg::sat32(-34'(v[1]));
            p[1] <= half_s;
            state <= S_SNAP1;
          end else begin
            state <= S_GRAV;
          end
        end
        S_SNAP1: begin
          phase <= !phase;
          if (phase) begin
            sq_acc <= sq_sum;
            lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
            if (lane == 2'd2) begin
              if (sq_sum <= 64'(stop_sq)) begin
                v[0] <= '0; v[1] <= '0; v[2] <= '0;
              end
              state <= S_GRAV;
            end
          end
        end
        S_GRAV: begin
          if (!has_g) state <= S_DAMP1;
          else if (resting) begin
            v[1] <= '0; p[1] <= half_s; state <= S_DAMP1;
          end else begin
            phase <= !phase;
            if (phase) begin
              v[lane] <= p_sum_v(v[lane], mres);
              if (lane == 2'd2) state <= S_DAMP1;
              lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
            end
          end
        end
        S_DAMP1: begin
          phase <= !phase;
          if (phase) begin
            d_tmp <= mres; state <= S_DAMP2;
          end
        end
        S_DAMP2: begin
          phase <= !phase;
          if (phase) begin
            v[lane] <= bbes_pkg::sat32(34'(v[lane]) - mres);
            sq_acc <= '0;
            if (lane == 2'd2) state <= S_SNAP2;
            else state <= S_DAMP1;
            lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
          end
        end
        S_SNAP2: begin
          phase <= !phase;
          if (phase) begin
            sq_acc <= sq_sum;
            lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
            if (lane == 2'd2) begin
              if (sq_sum <= 64'(stop_sq)) begin
                v[0] <= '0; v[1] <= '0; v[2] <= '0;
              end
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.pos_x = p[0];
  assign out_ch.pos_y = p[1];
  assign out_ch.pos_z = p[2];
  assign out_ch.vel_x = v[0];
  assign out_ch.vel_y = v[1];
  assign out_ch.vel_z = v[2];

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> out_ch.valid) else $error("result beat missing");
  a_lane: assert property (@(posedge clk) disable iff (rst)
    state == S_POS |-> lane != 2'd3) else $error("bad lane");
endmodule

[tb/tb_bbes_if.sv]
// ----------------------------------------------------------------------------
// tb_bbes_if
// notes on the channel interfaces used by the bouncing body testbench
// ----------------------------------------------------------------------------
// the channel interfaces come from the rtl interface file; this file holds
// only the testbench-side beat type shared by the driver and the predictor
`timescale 1ns / 1ps
package tb_bbes_pkg;
  typedef struct packed {
    logic               cmd;
    logic [63:0]        time_us;
    logic signed [31:0] px, py, pz, vx, vy, vz;
  } body_beat_t;
endpackage

[tb/tb_bouncing_body_euler_step_top.sv]
// ----------------------------------------------------------------------------
// tb_bouncing_body_euler_step_top
// drives load and advance beats into the body integrator, predicts each
// resulting body state in fixed point and compares every output beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_bouncing_body_euler_step_top;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz;
  } body_state_t;

  logic clk;
  logic rst;
  bbes_in_if  in_ch();
  bbes_out_if out_ch();
  bbes_cfg_if cfg();

  bouncing_body_euler_step_top uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  // predictor copy of registers and body
  logic signed [31:0] grav [3];
  logic [15:0]        damp;
  logic [30:0]        floor_h;
  logic [62:0]        snap_sq;
  logic [30:0]        rest_lim;
  logic signed [31:0] pos [3] = '{0, 0, 0};
  logic signed [31:0] vel [3] = '{0, 0, 0};
  logic [63:0]        last_us = '0;

  tb_bbes_pkg::body_beat_t beat_q [$];
  body_state_t state_q [$];
  int  mismatches = 0;
  longint cycles = 0;
  tb_bbes_pkg::body_beat_t drv_beat;
  body_state_t exp_st;
  body_state_t got_st;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  bit calm;  // stretch with no idling
  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round(a*b/2^sh) ties away from zero
  function automatic longint rnd_prod(longint a, longint b, int sh);
    longint p;
    longint unsigned m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  // squared speed at or below the snap level
  function automatic bit below_snap(logic signed [31:0] a, logic signed [31:0] b,
                                    logic signed [31:0] c);
    longint unsigned s;
    s = longint'(a) * longint'(a) + longint'(b) * longint'(b)
      + longint'(c) * longint'(c);
    return s <= {1'b0, snap_sq};
  endfunction

  // euler step prediction for one beat
  function automatic body_state_t integrate(tb_bbes_pkg::body_beat_t b);
    longint unsigned us;
    longint dt;
    bit has_g, has_v, resting;
    logic signed [31:0] p [3];
    logic signed [31:0] v [3];
    longint d;
    if (b.cmd == bbes_pkg::CMD_LOAD) begin
      last_us = b.time_us;
      pos[0] = b.px; pos[1] = b.py; pos[2] = b.pz;
      vel[0] = b.vx; vel[1] = b.vy; vel[2] = b.vz;
    end else begin
      us = b.time_us - last_us;
      if (us > 64'd67108863) us = 64'd67108863;
      dt = longint'(((us << bbes_pkg::DtFrac) + 64'd500000) / 64'd1000000);
      last_us = b.time_us;
      has_g = grav[0] != 0 || grav[1] != 0 || grav[2] != 0;
      has_v = vel[0] != 0 || vel[1] != 0 || vel[2] != 0;
      resting = longint'(pos[1]) <= longint'(floor_h)
        && longint'(vel[1]) >= -longint'(rest_lim)
        && longint'(vel[1]) <= longint'(rest_lim) && grav[1] < 0;
      if (has_v || has_g) begin
        for (int i = 0; i < 3; i++) begin
          v[i] = vel[i];
          p[i] = clip32(longint'(pos[i]) + rnd_prod(v[i], dt, bbes_pkg::DtFrac));
        end
        // floor bounce
        if (longint'(p[1]) <= longint'(floor_h)) begin
          v[1] = clip32(-longint'(v[1]));
          if (below_snap(v[0], v[1], v[2])) for (int i = 0; i < 3; i++) v[i] = 0;
          p[1] = floor_h;
        end
        if (has_g && !resting)
          for (int i = 0; i < 3; i++)
            v[i] = clip32(longint'(v[i]) + rnd_prod(grav[i], dt, bbes_pkg::DtFrac));
        if (has_g && resting) begin
          v[1] = 0;
          p[1] = floor_h;
        end
        // damping
        for (int i = 0; i < 3; i++) begin
          d = rnd_prod(v[i], longint'(damp), 16);
          v[i] = clip32(longint'(v[i]) - rnd_prod(d, dt, bbes_pkg::DtFrac));
        end
        if (below_snap(v[0], v[1], v[2])) for (int i = 0; i < 3; i++) v[i] = 0;
        for (int i = 0; i < 3; i++) begin
          pos[i] = p[i];
          vel[i] = v[i];
        end
      end
    end
    return '{pos[0], pos[1], pos[2], vel[0], vel[1], vel[2]};
  endfunction

  // input driver, front of the queue is the beat on the wires
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid      <= 1'b0;
      in_ch.cmd        <= bbes_pkg::CMD_LOAD;
      in_ch.time_us    <= '0;
      in_ch.load_pos_x <= '0;
      in_ch.load_pos_y <= '0;
      in_ch.load_pos_z <= '0;
      in_ch.load_vel_x <= '0;
      in_ch.load_vel_y <= '0;
      in_ch.load_vel_z <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) void'(beat_q.pop_front());
      if (beat_q.size() != 0 && !idle_now()) begin
        drv_beat = beat_q[0];
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= drv_beat.cmd;
        in_ch.time_us    <= drv_beat.time_us;
        in_ch.load_pos_x <= drv_beat.px;
        in_ch.load_pos_y <= drv_beat.py;
        in_ch.load_pos_z <= drv_beat.pz;
        in_ch.load_vel_x <= drv_beat.vx;
        in_ch.load_vel_y <= drv_beat.vy;
        in_ch.load_vel_z <= drv_beat.vz;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predict on acceptance
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      state_q.push_back(integrate({in_ch.cmd, in_ch.time_us, in_ch.load_pos_x,
        in_ch.load_pos_y, in_ch.load_pos_z, in_ch.load_vel_x, in_ch.load_vel_y,
        in_ch.load_vel_z}));
  end

  // result monitor with random stall
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (state_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          exp_st = state_q.pop_front();
          got_st = {out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
            out_ch.vel_x, out_ch.vel_y, out_ch.vel_z};
          if (got_st !== exp_st) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp p=%0d,%0d,%0d v=%0d,%0d,%0d",
                " got p=%0d,%0d,%0d v=%0d,%0d,%0d"},
                exp_st.px, exp_st.py, exp_st.pz, exp_st.vx, exp_st.vy, exp_st.vz,
                got_st.px, got_st.py, got_st.pz, got_st.vx, got_st.vy, got_st.vz);
          end
        end
      end
      out_ch.ready <= !idle_now();
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(bbes_pkg::reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      bbes_pkg::REG_GRAV_X:   grav[0] = value[31:0];
      bbes_pkg::REG_GRAV_Y:   grav[1] = value[31:0];
      bbes_pkg::REG_GRAV_Z:   grav[2] = value[31:0];
      bbes_pkg::REG_DAMPING:  damp = value[15:0];
      bbes_pkg::REG_HALF_H:   floor_h = value[30:0];
      bbes_pkg::REG_STOP_SQ:  snap_sq = value[62:0];
      bbes_pkg::REG_REST_LIM: rest_lim = value[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || state_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_q(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(8 << 24)) - (4 << 24);
      default: return $signed($urandom_range(1 << 22)) - (1 << 21);
    endcase
  endfunction

  function automatic tb_bbes_pkg::body_beat_t mk_load(logic [63:0] t);
    automatic int m = $urandom_range(9) == 0 ? 0 : $urandom_range(1, 2);
    return '{bbes_pkg::CMD_LOAD, t, rnd_q(m), rnd_q(m), rnd_q(m), rnd_q(m), rnd_q(m),
      rnd_q(m)};
  endfunction

  function automatic tb_bbes_pkg::body_beat_t mk_adv(logic [63:0] t);
    return '{bbes_pkg::CMD_ADVANCE, t, $urandom, $urandom, $urandom, $urandom, $urandom,
      $urandom};
  endfunction

  logic [63:0] now_us;

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0: now_us = {$urandom, $urandom};
        1: now_us = now_us - $urandom_range(1000);
        2: now_us = now_us + $urandom_range(90000000);
        default: now_us = now_us + $urandom_range(40000);
      endcase
      beat_q.push_back($urandom_range(7) == 0 ? mk_load(now_us) : mk_adv(now_us));
    end
    while (beat_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] big;
    rst = 1'b1;
    cfg.valid = 0; cfg.index = bbes_pkg::REG_GRAV_X; cfg.data = 0;
    calm = 1;
    grav[0] = 0; grav[1] = 0; grav[2] = 0;
    damp = 16'd64881; floor_h = 31'd838861; snap_sq = 63'd1; rest_lim = 31'd16;
    now_us = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset defaults, no motion, extremes and special cases
    big = 64'hFFFF_FFFF_FFFF_FFFF;
    beat_q.push_back(mk_adv(64'd1000));
    beat_q.push_back('{bbes_pkg::CMD_LOAD, 64'd0, 32'sh7FFFFFFF, 32'sh80000000,
      32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF});
    beat_q.push_back(mk_adv(big));
    beat_q.push_back(mk_adv(64'd5));
    beat_q.push_back('{bbes_pkg::CMD_LOAD, big, 32'sh80000000, 32'sh7FFFFFFF,
      32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
    beat_q.push_back(mk_adv(64'd10));
    beat_q.push_back('{bbes_pkg::CMD_LOAD, 64'd0, 0, 32'sd1 <<< 24, 0, 0,
      -(32'sd3 <<< 24), 0});
    beat_q.push_back(mk_adv(64'd500000));
    beat_q.push_back(mk_adv(64'd500001));
    beat_q.push_back(mk_adv(64'd400000));
    beat_q.push_back('{bbes_pkg::CMD_LOAD, 64'd0, 0, 0, 0, 1, 0, 0});
    beat_q.push_back(mk_adv(64'd16667));
    drain();
    write_reg(bbes_pkg::REG_GRAV_Y, -(64'd164 << 20));
    beat_q.push_back('{bbes_pkg::CMD_LOAD, 64'd0, 0, 838861, 0, 0, 8, 0});
    beat_q.push_back(mk_adv(64'd16667));
    beat_q.push_back(mk_adv(64'd33333));
    beat_q.push_back('{bbes_pkg::CMD_LOAD, 64'd0, 5, 32'sd2 <<< 24, 0, 32'sd1 <<< 20,
      0, 0});
    for (int i = 1; i < 8; i++) beat_q.push_back(mk_adv(64'd16667 * i));
    drain();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 2);
      case (ph)
        0: ;
        1: begin
          write_reg(bbes_pkg::REG_DAMPING, 64'd0);
          write_reg(bbes_pkg::REG_STOP_SQ, 64'd0);
        end
        2: begin
          write_reg(bbes_pkg::REG_DAMPING, 64'hFFFF);
          write_reg(bbes_pkg::REG_HALF_H, 64'h7FFFFFFF);
        end
        3: begin
          write_reg(bbes_pkg::REG_GRAV_X, 64'h7FFFFFFF);
          write_reg(bbes_pkg::REG_GRAV_Y, 64'h80000000);
          write_reg(bbes_pkg::REG_GRAV_Z, 64'hFFFFFFFF_80000000);
          write_reg(bbes_pkg::REG_HALF_H, 64'd0);
          write_reg(bbes_pkg::REG_STOP_SQ, 64'h7FFFFFFF_FFFFFFFF);
          write_reg(bbes_pkg::REG_REST_LIM, 64'h7FFFFFFF);
        end
        4: begin
          write_reg(bbes_pkg::REG_STOP_SQ, {32'd0, $urandom});
          write_reg(bbes_pkg::REG_REST_LIM, 64'($urandom_range(1 << 20)));
          write_reg(bbes_pkg::REG_HALF_H, 64'd838861);
          write_reg(bbes_pkg::REG_GRAV_X, 0); write_reg(bbes_pkg::REG_GRAV_Z, 0);
          write_reg(bbes_pkg::REG_GRAV_Y, -(64'd164 << 20));
        end
        5: begin
          write_reg(bbes_pkg::REG_GRAV_Y, 0);
          write_reg(bbes_pkg::REG_DAMPING, 64'd64881);
        end
        default: begin
          write_reg(bbes_pkg::REG_GRAV_X, {32'd0, rnd_q(1)});
          write_reg(bbes_pkg::REG_GRAV_Y, {32'd0, rnd_q(1)});
          write_reg(bbes_pkg::REG_GRAV_Z, {32'd0, rnd_q(2)});
          write_reg(bbes_pkg::REG_DAMPING, 64'($urandom_range(65535)));
          write_reg(bbes_pkg::REG_HALF_H, {32'd0, $urandom} & 64'h7FFFFFFF);
          write_reg(bbes_pkg::REG_STOP_SQ, {$urandom, $urandom} >> $urandom_range(1, 63));
          write_reg(bbes_pkg::REG_REST_LIM, {32'd0, $urandom} >> $urandom_range(0, 20));
        end
      endcase
      random_phase(200);
      drain();
    end

    if (mismatches == 0 && state_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
